// File: src/sadf_pkg.sv
// Shared types, codes and defaults of the stack allocator with deferred free.
package sadf_pkg;

  localparam int unsigned ARENA_BYTES_DEF = 4096;

  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_FREE   = 1'b1;

  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [12:0] size_bytes;
    logic [2:0]  align_log2;
    logic [11:0] block_offset;
  } sadf_in_t;

  typedef struct packed {
    logic [11:0] result_offset;
    logic        status;
    logic [12:0] top_after;
  } sadf_out_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic res_load;
    logic mem_rd;
    logic wr_pad_link;
    logic wr_pad_inv;
    logic wr_top_inv;
    logic wr_end_link;
    logic top_alloc;
    logic top_boff;
    logic top_link;
    logic out_load;
  } sadf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic reject;
    logic pad_eq;
    logic top_in_range;
    logic end_hit;
    logic end_in_range;
    logic link_valid;
  } sadf_sts_t;

endpackage

// File: src/sadf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sadf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sadf_ctrl.sv
// Controller state machine that sequences allocate, free and link walks.
module sadf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sadf_pkg::sadf_sts_t sts_i,
  output sadf_pkg::sadf_cmd_t cmd_o
);
  import sadf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MV_DATA,
    S_MV_CLR,
    S_WALK_RD,
    S_WALK_CHK,
    S_DONE
  } state_e;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  sadf_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_load = 1'b1;
        if (!sts_i.is_free) begin
          if (sts_i.reject) begin
            state_d = S_DONE;
          end else if (sts_i.pad_eq) begin
            cmd.top_alloc = 1'b1;
            state_d       = S_DONE;
          end else if (sts_i.top_in_range) begin
            cmd.mem_rd = 1'b1;
            state_d    = S_MV_DATA;
          end else begin
            cmd.wr_pad_inv = 1'b1;
            cmd.top_alloc  = 1'b1;
            state_d        = S_DONE;
          end
        end else if (sts_i.end_hit) begin
          cmd.top_boff = 1'b1;
          state_d      = S_WALK_RD;
        end else begin
          cmd.wr_end_link = sts_i.end_in_range;
          state_d         = S_DONE;
        end
      end
      S_MV_DATA: begin
        cmd.wr_pad_link = 1'b1;
        state_d         = S_MV_CLR;
      end
      S_MV_CLR: begin
        cmd.wr_top_inv = 1'b1;
        cmd.top_alloc  = 1'b1;
        state_d        = S_DONE;
      end
      S_WALK_RD: begin
        if (sts_i.top_in_range) begin
          cmd.mem_rd = 1'b1;
          state_d    = S_WALK_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK_CHK: begin
        if (sts_i.link_valid) begin
          cmd.wr_top_inv = 1'b1;
          cmd.top_link   = 1'b1;
          state_d        = S_WALK_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: src/sadf_dp.sv
// Datapath with the top register, offset arithmetic, link memory and result register.
module sadf_dp #(
  parameter int unsigned ARENA_BYTES = sadf_pkg::ARENA_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sadf_pkg::sadf_in_t  in_data_i,
  input  sadf_pkg::sadf_cmd_t cmd_i,
  output sadf_pkg::sadf_sts_t sts_o,
  output sadf_pkg::sadf_out_t out_data_o
);
  import sadf_pkg::*;

  localparam int unsigned AW      = $clog2(ARENA_BYTES);
  localparam int unsigned TOP_MAX = (ARENA_BYTES > 4095) ? ARENA_BYTES : 4095;
  localparam int unsigned TW      = $clog2(TOP_MAX + 1);
  localparam int unsigned WW      = $clog2(TOP_MAX + 128 + 8192);
  localparam int unsigned LW      = AW + 1;

  sadf_in_t    item_q;
  logic [TW-1:0] top_q, top_d;
  logic [AW-1:0] clr_q;
  logic [11:0]   res_off_q;
  logic          res_status_q;
  sadf_out_t     out_q;

  logic [WW-1:0] top_w, size_w, boff_w, arena_w, mask_w, pad_w, sum_w, end_w;
  logic [LW-1:0] rdata, wdata;
  logic [AW-1:0] waddr;
  logic          we;

  assign top_w   = WW'(top_q);
  assign size_w  = WW'(item_q.size_bytes);
  assign boff_w  = WW'(item_q.block_offset);
  assign arena_w = WW'(ARENA_BYTES);
  assign mask_w  = (WW'(1) << item_q.align_log2) - WW'(1);
  assign pad_w   = (top_w + mask_w) & ~mask_w;
  assign sum_w   = pad_w + size_w;
  assign end_w   = boff_w + size_w;

  always_comb begin
    sts_o              = '0;
    sts_o.clr_last     = (clr_q == AW'(ARENA_BYTES - 1));
    sts_o.is_free      = (item_q.operation == OP_FREE);
    sts_o.reject       = (item_q.size_bytes == '0) || (sum_w > arena_w);
    sts_o.pad_eq       = (pad_w == top_w);
    sts_o.top_in_range = (top_w < arena_w);
    sts_o.end_hit      = (end_w == top_w);
    sts_o.end_in_range = (end_w < arena_w);
    sts_o.link_valid   = rdata[LW-1];
  end

  always_comb begin
    we    = 1'b1;
    waddr = clr_q;
    wdata = '0;
    if (cmd_i.clr_wr) begin
      waddr = clr_q;
    end else if (cmd_i.wr_pad_link) begin
      waddr = pad_w[AW-1:0];
      wdata = rdata;
    end else if (cmd_i.wr_pad_inv) begin
      waddr = pad_w[AW-1:0];
    end else if (cmd_i.wr_top_inv) begin
      waddr = top_q[AW-1:0];
    end else if (cmd_i.wr_end_link) begin
      waddr = end_w[AW-1:0];
      wdata = {1'b1, boff_w[AW-1:0]};
    end else begin
      we = 1'b0;
    end
  end

  sadf_ram #(
    .WIDTH (LW),
    .DEPTH (ARENA_BYTES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (top_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    top_d = top_q;
    if (cmd_i.top_alloc) begin
      top_d = sum_w[TW-1:0];
    end else if (cmd_i.top_boff) begin
      top_d = TW'(item_q.block_offset);
    end else if (cmd_i.top_link) begin
      top_d = TW'(rdata[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      clr_q <= '0;
    end else begin
      top_q <= top_d;
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.res_load) begin
      if (sts_o.is_free) begin
        res_off_q    <= '0;
        res_status_q <= ST_DONE;
      end else if (sts_o.reject) begin
        res_off_q    <= '0;
        res_status_q <= ST_REJECT;
      end else begin
        res_off_q    <= pad_w[11:0];
        res_status_q <= ST_DONE;
      end
    end
    if (cmd_i.out_load) begin
      out_q.result_offset <= res_off_q;
      out_q.status        <= res_status_q;
      out_q.top_after     <= top_w[12:0];
    end
  end

  assign out_data_o = out_q;

endmodule

// File: src/stack_allocator_deferred_free.sv
// Top level of the stack bump allocator with deferred free of non-top blocks.
// A free below the top, a rejected or an aligned allocate goes from S_DECODE to S_DONE; an
// allocate that moves a link passes S_MV_DATA and S_MV_CLR; a free of the top block that
// releases N deferred links loops S_WALK_RD, S_WALK_CHK in a read-then-clear walk of the link RAM.
// One item is in work at a time; the next input can be taken in the cycle the result appears.
// After reset the link RAM is cleared one entry a cycle, all ARENA_BYTES, with input stalled.
module stack_allocator_deferred_free #(
  parameter int unsigned ARENA_BYTES = sadf_pkg::ARENA_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sadf_pkg::sadf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sadf_pkg::sadf_out_t out_data_o
);
  import sadf_pkg::*;

  sadf_cmd_t cmd;
  sadf_sts_t sts;

  sadf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sadf_dp #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// File: src/sadf_checker.sv
// Port-level checker of the allocator and its bind to the top level.
module sadf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sadf_pkg::sadf_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sadf_pkg::sadf_out_t out_data_o
);
  import sadf_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("Stalled input transfer changed or was dropped.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed or was dropped.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken while an item is still in work.");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o && !out_valid_o)
    else $error("Block not quiet during reset.");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_REJECT) |-> (out_data_o.result_offset == '0))
    else $error("Rejected allocate reports a nonzero offset.");

endmodule

bind stack_allocator_deferred_free sadf_checker u_sadf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
